>>> rtl/core/fzoc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the footprint zone occupancy check
// no dependencies

package fzoc_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned MarginW = 8;
  localparam int unsigned TolW    = 12;
  localparam int unsigned RadSqW  = 20;
  localparam int unsigned CostW   = 8;

  // zone slots in the counter bank
  localparam int unsigned NZones  = 9;
  localparam int unsigned ZFl     = 0;
  localparam int unsigned ZFr     = 1;
  localparam int unsigned ZBr     = 2;
  localparam int unsigned ZBl     = 3;
  localparam int unsigned ZFront  = 4;
  localparam int unsigned ZLeft   = 5;
  localparam int unsigned ZRight  = 6;
  localparam int unsigned ZBack   = 7;
  localparam int unsigned ZDisc   = 8;

  // register map, one 32-bit word each
  localparam int unsigned AddrW   = 5;
  localparam int unsigned IdxW    = 3;
  localparam logic [IdxW-1:0] RegBackX  = 3'd0;
  localparam logic [IdxW-1:0] RegFrontX = 3'd1;
  localparam logic [IdxW-1:0] RegRightY = 3'd2;
  localparam logic [IdxW-1:0] RegLeftY  = 3'd3;
  localparam logic [IdxW-1:0] RegMargin = 3'd4;
  localparam logic [IdxW-1:0] RegTol    = 3'd5;
  localparam logic [IdxW-1:0] RegRadSq  = 3'd6;

  localparam logic [TolW-1:0] TolReset = 12'd1;

  typedef struct packed {
    logic [CoordW-1:0]  box_back_x;
    logic [CoordW-1:0]  box_front_x;
    logic [CoordW-1:0]  box_right_y;
    logic [CoordW-1:0]  box_left_y;
    logic [MarginW-1:0] margin_cells;
    logic [TolW-1:0]    tolerance;
    logic [RadSqW-1:0]  radius_sq;
  } cfg_t;

  typedef struct packed {
    logic front_free;
    logic left_free;
    logic right_free;
    logic rear_free;
    logic disc_free;
  } flags_t;

endpackage

>>> rtl/core/fzoc_cell_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one grid cell
// no dependencies

interface fzoc_cell_if;
  logic              valid;
  logic              ready;
  logic [9:0]        cell_x;
  logic [9:0]        cell_y;
  logic signed [7:0] cost;
  logic              last_cell;

  modport source (output valid, output cell_x, output cell_y, output cost,
                  output last_cell, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input cost,
                  input last_cell, output ready);
endinterface

>>> rtl/core/fzoc_flag_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying the five clear flags of one frame
// no dependencies

interface fzoc_flag_if;
  logic valid;
  logic ready;
  logic front_free;
  logic left_free;
  logic right_free;
  logic rear_free;
  logic disc_free;

  modport source (output valid, output front_free, output left_free,
                  output right_free, output rear_free, output disc_free,
                  input ready);
  modport sink   (input valid, input front_free, input left_free,
                  input right_free, input rear_free, input disc_free,
                  output ready);
endinterface

>>> rtl/core/fzoc_cfg_regs.sv
`timescale 1ns / 1ps
// apb register file for box geometry, margin, tolerance and disc radius
// depends on fzoc_pkg

module fzoc_cfg_regs
  import fzoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t            cfg_q;
  logic            wr_en;
  logic [IdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_back_x   <= '0;
      cfg_q.box_front_x  <= '0;
      cfg_q.box_right_y  <= '0;
      cfg_q.box_left_y   <= '0;
      cfg_q.margin_cells <= '0;
      cfg_q.tolerance    <= TolReset;
      cfg_q.radius_sq    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegBackX:  cfg_q.box_back_x   <= pwdata[CoordW-1:0];
        RegFrontX: cfg_q.box_front_x  <= pwdata[CoordW-1:0];
        RegRightY: cfg_q.box_right_y  <= pwdata[CoordW-1:0];
        RegLeftY:  cfg_q.box_left_y   <= pwdata[CoordW-1:0];
        RegMargin: cfg_q.margin_cells <= pwdata[MarginW-1:0];
        RegTol:    cfg_q.tolerance    <= pwdata[TolW-1:0];
        RegRadSq:  cfg_q.radius_sq    <= pwdata[RadSqW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegBackX:  prdata = 32'(cfg_q.box_back_x);
      RegFrontX: prdata = 32'(cfg_q.box_front_x);
      RegRightY: prdata = 32'(cfg_q.box_right_y);
      RegLeftY:  prdata = 32'(cfg_q.box_left_y);
      RegMargin: prdata = 32'(cfg_q.margin_cells);
      RegTol:    prdata = 32'(cfg_q.tolerance);
      RegRadSq:  prdata = 32'(cfg_q.radius_sq);
      default:   prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/fzoc_zone_match.sv
`timescale 1ns / 1ps
// per-cell zone membership: eight rectangle tests and the disc distance test
// depends on fzoc_pkg

module fzoc_zone_match
  import fzoc_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 1024
) (
  input  logic              [CoordW-1:0] cell_x_i,
  input  logic              [CoordW-1:0] cell_y_i,
  input  logic signed       [CostW-1:0]  cost_i,
  input  cfg_t                           cfg_i,
  output logic              [NZones-1:0] hits_o
);

  // coordinates widened to signed so bounds may go below zero or past the grid
  localparam int unsigned SW = CoordW + 2;

  logic signed [SW-1:0] x, y, m, bx, fx, ry, ly;
  logic                 xf, xb, xm, yl, yr, ym;
  logic                 counted;
  logic [CoordW:0]      sum_x, sum_y;
  logic [CoordW-1:0]    cx, cy, adx, ady;
  logic signed [CoordW+1:0] dx, dy;
  logic [2*CoordW-1:0]  sqx, sqy;
  logic [2*CoordW:0]    d2;
  logic                 in_disc;

  always_comb begin
    x  = $signed({2'b00, cell_x_i});
    y  = $signed({2'b00, cell_y_i});
    m  = $signed({4'b0000, cfg_i.margin_cells});
    bx = $signed({2'b00, cfg_i.box_back_x});
    fx = $signed({2'b00, cfg_i.box_front_x});
    ry = $signed({2'b00, cfg_i.box_right_y});
    ly = $signed({2'b00, cfg_i.box_left_y});

    xf = (x >= fx)     && (x <= fx + m);
    xb = (x >= bx - m) && (x <= bx);
    xm = (x >= bx)     && (x <= fx);
    yl = (y >= ly)     && (y <= ly + m);
    yr = (y >= ry - m) && (y <= ry);
    ym = (y >= ry)     && (y <= ly);

    // disc center is the floored box midpoint
    sum_x = {1'b0, cfg_i.box_back_x} + {1'b0, cfg_i.box_front_x};
    sum_y = {1'b0, cfg_i.box_right_y} + {1'b0, cfg_i.box_left_y};
    cx    = sum_x[CoordW:1];
    cy    = sum_y[CoordW:1];
    dx    = $signed({2'b00, cell_x_i}) - $signed({2'b00, cx});
    dy    = $signed({2'b00, cell_y_i}) - $signed({2'b00, cy});
    adx   = dx[CoordW+1] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady   = dy[CoordW+1] ? CoordW'(-dy) : dy[CoordW-1:0];
    sqx   = adx * adx;
    sqy   = ady * ady;
    d2    = {1'b0, sqx} + {1'b0, sqy};
    in_disc = d2 <= (2*CoordW+1)'(cfg_i.radius_sq);

    counted = (cost_i > 0) && (32'(cell_x_i) < GRID_SIZE) && (32'(cell_y_i) < GRID_SIZE);

    hits_o         = '0;
    hits_o[ZFl]    = xf && yl;
    hits_o[ZFr]    = xf && yr;
    hits_o[ZBr]    = xb && yr;
    hits_o[ZBl]    = xb && yl;
    hits_o[ZFront] = xf && ym;
    hits_o[ZLeft]  = xm && yl;
    hits_o[ZRight] = xm && yr;
    hits_o[ZBack]  = xb && ym;
    hits_o[ZDisc]  = in_disc;
    if (!counted) begin
      hits_o = '0;
    end
  end

endmodule

>>> rtl/core/fzoc_zone_count.sv
`timescale 1ns / 1ps
// bank of nine saturating zone counters and the frame-end flag evaluation
// depends on fzoc_pkg

module fzoc_zone_count
  import fzoc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [NZones-1:0] hits_i,
  input  logic              last_i,
  input  logic [TolW-1:0]   tolerance_i,
  output flags_t            flags_o
);

  localparam int unsigned SumW = (COUNT_BITS + 2 > TolW) ? COUNT_BITS + 2 : TolW;

  logic [COUNT_BITS-1:0] cnt_q [NZones];
  logic [COUNT_BITS-1:0] cnt_d [NZones];
  logic [SumW-1:0]       tol_w;

  // flags see the counts including the cell that closes the frame
  always_comb begin
    for (int z = 0; z < NZones; z++) begin
      cnt_d[z] = (hits_i[z] && !(&cnt_q[z])) ? cnt_q[z] + 1'b1 : cnt_q[z];
    end
    tol_w = SumW'(tolerance_i);
    flags_o.front_free = (SumW'(cnt_d[ZFront]) + SumW'(cnt_d[ZFl]) + SumW'(cnt_d[ZFr]))
                         < tol_w;
    flags_o.left_free  = (SumW'(cnt_d[ZLeft]) + SumW'(cnt_d[ZFl]) + SumW'(cnt_d[ZBl]))
                         < tol_w;
    flags_o.right_free = (SumW'(cnt_d[ZRight]) + SumW'(cnt_d[ZFr]) + SumW'(cnt_d[ZBr]))
                         < tol_w;
    flags_o.rear_free  = (SumW'(cnt_d[ZBack]) + SumW'(cnt_d[ZBl]) + SumW'(cnt_d[ZBr]))
                         < tol_w;
    flags_o.disc_free  = SumW'(cnt_d[ZDisc]) < tol_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < NZones; z++) begin
        cnt_q[z] <= '0;
      end
    end else if (step_i) begin
      for (int z = 0; z < NZones; z++) begin
        cnt_q[z] <= last_i ? '0 : cnt_d[z];
      end
    end
  end

endmodule

>>> rtl/core/footprint_zone_occupancy_check.sv
`timescale 1ns / 1ps
// top level: register file, cell input stage, zone match, counter bank, flag output
// depends on fzoc_pkg, fzoc_cell_if, fzoc_flag_if and the fzoc_* submodules

// Takes one grid cell per clock in raster order and counts occupied cells
// (cost above zero) in nine zones around the configured robot box. A cell
// marked last closes the frame: after the input register and the hit register,
// the five clear flags are registered and offered on the output channel and
// the counters restart from zero. Throughput is one cell per cycle, set by the
// single pass from the input register through the zone compares and one
// squaring per axis into a hit register, then the counter bank. The input side
// pauses only when a frame-end cell reaches the counters while the previous
// flag set is still waiting to be taken. Configuration is to be written over
// APB while no cell is in flight; the user must ensure it, the block does not.
module footprint_zone_occupancy_check
  import fzoc_pkg::*;
#(
  parameter int unsigned GRID_SIZE  = 1024,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  fzoc_cell_if.sink        cell_i,
  fzoc_flag_if.source      flags_o
);

  cfg_t              cfg;
  logic              adv;

  logic              s1_vld_q;
  logic [CoordW-1:0] s1_x_q, s1_y_q;
  logic signed [CostW-1:0] s1_cost_q;
  logic              s1_last_q;

  logic [NZones-1:0] hits;
  logic              s2_vld_q;
  logic [NZones-1:0] s2_hits_q;
  logic              s2_last_q;

  flags_t            flags_d, flags_q;
  logic              out_vld_q, out_vld_d;
  logic              frame_end;

  fzoc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the pipe only holds when a new flag set would overwrite one not yet taken
  assign frame_end  = s2_vld_q & s2_last_q;
  assign adv        = !(frame_end && out_vld_q && !flags_o.ready);
  assign cell_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= cell_i.valid;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q    <= cell_i.cell_x;
      s1_y_q    <= cell_i.cell_y;
      s1_cost_q <= cell_i.cost;
      s1_last_q <= cell_i.last_cell;
      s2_hits_q <= hits;
      s2_last_q <= s1_last_q;
    end
  end

  fzoc_zone_match #(
    .GRID_SIZE (GRID_SIZE)
  ) u_match (
    .cell_x_i (s1_x_q),
    .cell_y_i (s1_y_q),
    .cost_i   (s1_cost_q),
    .cfg_i    (cfg),
    .hits_o   (hits)
  );

  fzoc_zone_count #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv & s2_vld_q),
    .hits_i      (s2_hits_q),
    .last_i      (s2_last_q),
    .tolerance_i (cfg.tolerance),
    .flags_o     (flags_d)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && frame_end) begin
      out_vld_d = 1'b1;
    end else if (flags_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && frame_end) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o.valid      = out_vld_q;
  assign flags_o.front_free = flags_q.front_free;
  assign flags_o.left_free  = flags_q.left_free;
  assign flags_o.right_free = flags_q.right_free;
  assign flags_o.rear_free  = flags_q.rear_free;
  assign flags_o.disc_free  = flags_q.disc_free;

endmodule
